// ===== src/xor_checked_feedback_deframer_top_assert.svh =====
// Assertion macros for the serial feedback frame receiver.
// Included by the top level module, which checks its own control logic.
`ifndef XOR_CHECKED_FEEDBACK_DEFRAMER_TOP_ASSERT_SVH
`define XOR_CHECKED_FEEDBACK_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define XCFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

`define XCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define XCFD_ASSERT(label, clk, rst_n, prop)

`define XCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/xcfd_pkg.sv =====
// Shared constants and types for the serial feedback frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package xcfd_pkg;

    localparam int FRAME_LEN   = 18;
    localparam int WORD_COUNT  = 9;
    localparam int COUNT_W     = 5;
    localparam int PADDR_W     = 3;

    localparam logic [15:0] START_RESET = 16'hABCD;

    localparam logic [COUNT_W-1:0] COUNT_IDLE  = 5'd0;
    localparam logic [COUNT_W-1:0] COUNT_START = 5'd2;
    localparam logic [COUNT_W-1:0] COUNT_LAST  = 5'd17;

    localparam logic [0:0] REG_START_WORD = 1'b0;

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    typedef logic [FRAME_LEN-1:0][7:0] frame_t;

    typedef struct packed {
        logic        status;
        logic [15:0] command_one;
        logic [15:0] command_two;
        logic [15:0] speed_right;
        logic [15:0] speed_left;
        logic [15:0] battery_voltage;
        logic [15:0] board_temperature;
        logic [15:0] led_command;
    } result_t;

endpackage

// ===== src/xcfd_cell.sv =====
// One byte cell of the receive shift chain.
// Depends on nothing; instantiated in a row by the top level.
`timescale 1ns / 1ps

module xcfd_cell
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic [7:0] din,
    output logic [7:0] dout
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = shift_en ? din : byte_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign dout = byte_reg;

endmodule

// ===== src/xcfd_check.sv =====
// Frame word extraction and XOR check word comparison.
// Depends on xcfd_pkg.
`timescale 1ns / 1ps

module xcfd_check
    import xcfd_pkg::*;
(
    input  frame_t      frame,
    input  logic [15:0] start_word,
    output result_t     result
);

    logic [WORD_COUNT-1:0][15:0] words;
    logic [15:0]                 xor_sum;
    logic                        good;

    always_comb
    begin
        for (int k = 0; k < WORD_COUNT; k++)
        begin
            words[k] = {frame[2*k+1], frame[2*k]};
        end
    end

    always_comb
    begin
        xor_sum = 16'd0;
        for (int k = 0; k < WORD_COUNT - 1; k++)
        begin
            xor_sum = xor_sum ^ words[k];
        end
    end

    assign good = (words[0] == start_word) && (xor_sum == words[WORD_COUNT-1]);

    always_comb
    begin
        result.status            = good ? STATUS_GOOD : STATUS_BAD;
        result.command_one       = words[1];
        result.command_two       = words[2];
        result.speed_right       = words[3];
        result.speed_left        = words[4];
        result.battery_voltage   = words[5];
        result.board_temperature = words[6];
        result.led_command       = words[7];
    end

endmodule

// ===== src/xor_checked_feedback_deframer_top.sv =====
// Received bytes pass through a row of seventeen byte cells, one cell per accepted
// transaction, and the incoming byte completes the eighteen-byte frame. A byte is
// taken every cycle unless the input stalls. The frame check (start word compare and the XOR of eight words
// against the ninth) runs in the cycle of the eighteenth byte, and the result is
// written to the output register at the edge that accepts that byte, so out_valid
// rises in the cycle after it. The input stalls only while a result sits in that
// register and the output side stalls. A start word seen anywhere, even inside a
// frame or on its last byte, restarts the frame.
// Depends on xcfd_pkg, xcfd_cell, xcfd_check and the assertion macro header.
`timescale 1ns / 1ps
`include "xor_checked_feedback_deframer_top_assert.svh"

module xor_checked_feedback_deframer_top
    import xcfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,

    output logic                out_valid,
    input  logic                out_stall,
    output logic                frame_status,
    output logic signed [15:0]  command_one,
    output logic signed [15:0]  command_two,
    output logic signed [15:0]  speed_right,
    output logic signed [15:0]  speed_left,
    output logic signed [15:0]  battery_voltage,
    output logic signed [15:0]  board_temperature,
    output logic [15:0]         led_command
);

    logic [15:0]                start_word_reg;
    logic [15:0]                start_word_next;
    logic [COUNT_W-1:0]         count_reg;
    logic [COUNT_W-1:0]         count_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    result_t                    result_reg;
    result_t                    result_next;

    logic                       cfg_write;
    logic                       in_acc;
    logic                       start_hit;
    logic                       emit;
    logic [FRAME_LEN-2:0][7:0]  chain;
    frame_t                     frame;
    result_t                    check_result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[PADDR_W-1] == REG_START_WORD) ? {16'd0, start_word_reg} : 32'd0;

    always_comb
    begin
        start_word_next = start_word_reg;
        if (cfg_write && (paddr[PADDR_W-1] == REG_START_WORD))
        begin
            start_word_next = pwdata[15:0];
        end
    end

    assign in_stall = out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;

    genvar gi;
    generate
        for (gi = 0; gi < FRAME_LEN - 1; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                xcfd_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (in_acc),
                    .din      (rx_byte),
                    .dout     (chain[gi])
                );
            end
            else
            begin : g_body
                xcfd_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (in_acc),
                    .din      (chain[gi-1]),
                    .dout     (chain[gi])
                );
            end
        end
    endgenerate

    // The newest byte completes the frame; older bytes sit deeper in the chain.
    always_comb
    begin
        frame[FRAME_LEN-1] = rx_byte;
        for (int j = 0; j < FRAME_LEN - 1; j++)
        begin
            frame[j] = chain[FRAME_LEN-2-j];
        end
    end

    xcfd_check u_check
    (
        .frame      (frame),
        .start_word (start_word_reg),
        .result     (check_result)
    );

    assign start_hit = ({rx_byte, chain[0]} == start_word_reg);
    assign emit      = !start_hit && (count_reg == COUNT_LAST);

    always_comb
    begin
        count_next = count_reg;
        if (in_acc)
        begin
            priority if (start_hit)
            begin
                count_next = COUNT_START;
            end
            else if (emit)
            begin
                count_next = COUNT_IDLE;
            end
            else if ((count_reg >= COUNT_START) && (count_reg < COUNT_LAST))
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        result_next    = result_reg;
        if (in_acc && emit)
        begin
            out_valid_next = 1'b1;
            result_next    = check_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_word_reg <= START_RESET;
            count_reg      <= COUNT_IDLE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            start_word_reg <= start_word_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid         = out_valid_reg;
    assign frame_status      = result_reg.status;
    assign command_one       = result_reg.command_one;
    assign command_two       = result_reg.command_two;
    assign speed_right       = result_reg.speed_right;
    assign speed_left        = result_reg.speed_left;
    assign battery_voltage   = result_reg.battery_voltage;
    assign board_temperature = result_reg.board_temperature;
    assign led_command       = result_reg.led_command;

    `XCFD_ASSERT(a_count_legal, clk, rst_n, (count_reg <= COUNT_LAST) && (count_reg != 5'd1))
    `XCFD_ASSERT_NEXT(a_resync, clk, rst_n, in_acc && start_hit, count_reg == COUNT_START)
    `XCFD_ASSERT_NEXT(a_emit, clk, rst_n, in_acc && emit, out_valid_reg && (count_reg == COUNT_IDLE))

endmodule
